// ----- rtl/core/rbgs_pkg.sv -----
// ----------------------------------------------------------------------------
// rbgs_pkg
// Shared constants of the red-black Gauss-Seidel smoother.
// ----------------------------------------------------------------------------
package rbgs_pkg;
	localparam int GridSide = 129;
	localparam int Cells = GridSide * GridSide;
	localparam int AddrW = $clog2(Cells);
	localparam int IdxW = 8;
	localparam int ValW = 32;

	localparam logic [1:0] CMD_WRITE = 2'd0;
	localparam logic [1:0] CMD_RUN   = 2'd1;
	localparam logic [1:0] CMD_READ  = 2'd2;

	localparam logic [1:0] ST_WRITE = 2'd0;
	localparam logic [1:0] ST_RUN   = 2'd1;
	localparam logic [1:0] ST_READ  = 2'd2;
	localparam logic [1:0] ST_RANGE = 2'd3;

	localparam logic [1:0] REG_SIDE  = 2'd0;
	localparam logic [1:0] REG_SWEEP = 2'd1;
	localparam logic [1:0] REG_AREA  = 2'd2;
endpackage

// ----- rtl/core/red_black_gauss_seidel_smoother_core.sv -----
// ----------------------------------------------------------------------------
// red_black_gauss_seidel_smoother_core
// Red-black Gauss-Seidel smoother over a grid held in two memories.
// ----------------------------------------------------------------------------
// With the receiver ready, write and read beats pass through the input beat,
// a memory read, the result register, then the result beat, and no new input
// beat is taken while a result waits. A run beat scans every interior row and
// column once per color per sweep. For a point of the color being updated, a
// single read port on the solution memory serves its four neighbors one after
// another, the product and the sum are registered, then the write-back
// follows. A point of the other color goes from the point check straight to
// the step to the next point. Every point must be written before a run.
module red_black_gauss_seidel_smoother_core
	import rbgs_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	// command[1:0], column[9:2], row[17:10], solution_in[49:18], source_in[81:50]
	input  logic [87:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// solution_out[31:0]
	output logic [31:0] m_tdata,
	// status[1:0]
	output logic [1:0]  m_tuser
);
	localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_OUT = 4'd2, S_PT = 4'd3,
		S_N0 = 4'd4, S_N1 = 4'd5, S_N2 = 4'd6, S_N3 = 4'd7, S_N4 = 4'd8,
		S_MUL = 4'd9, S_WB = 4'd10, S_NEXT = 4'd11;

	logic [31:0] sol_mem [Cells];
	logic [31:0] src_mem [Cells];

	logic [7:0]  side_q;
	logic [3:0]  sweeps_q;
	logic [31:0] area_q;
	logic [3:0]  st_q;
	logic [7:0]  r_q, c_q, side_use;
	logic [3:0]  it_q;
	logic        par_q;
	logic [1:0]  cmd_q;
	logic [AddrW-1:0] base_q, raddr, waddr;
	logic        we;
	logic [31:0] wdata, rdata_q, srcdata_q, out_q;
	logic [1:0]  stat_q;
	logic        ov_q;
	logic signed [34:0] nsum_q;
	logic signed [63:0] prod_q;
	logic signed [65:0] tot;
	logic signed [63:0] qv;
	logic [31:0] sat;

	assign side_use = (side_q > 8'(GridSide)) ? 8'(GridSide) : side_q;
	assign s_tready = (st_q == S_IDLE) && !m_tvalid;
	assign m_tdata = out_q;
	assign m_tuser = stat_q;

	always_comb begin
		tot = 66'(prod_q >>> 32) + 66'(nsum_q);
		qv = 64'(tot >>> 2);
		if (qv > 64'sh7fffffff) sat = 32'h7fffffff;
		else if (qv < -64'sh80000000) sat = 32'h80000000;
		else sat = qv[31:0];
	end

	always_comb begin
		raddr = base_q;
		unique case (st_q)
			S_N0: raddr = base_q + AddrW'(1);
			S_N1: raddr = base_q - AddrW'(1);
			S_N2: raddr = base_q + AddrW'(GridSide);
			S_N3: raddr = base_q - AddrW'(GridSide);
			default: raddr = base_q;
		endcase
	end

	always_ff @(posedge clk) begin
		rdata_q <= sol_mem[raddr];
		srcdata_q <= src_mem[raddr];
		if (we) sol_mem[waddr] <= wdata;
		if (st_q == S_IDLE && s_tvalid && s_tready && s_tdata[1:0] == CMD_WRITE
			&& s_tdata[9:2] < side_use && s_tdata[17:10] < side_use)
			src_mem[waddr] <= s_tdata[81:50];
	end

	always_comb begin
		we = 1'b0;
		waddr = base_q;
		wdata = sat;
		if (st_q == S_IDLE) begin
			waddr = AddrW'(s_tdata[17:10]) * AddrW'(GridSide) + AddrW'(s_tdata[9:2]);
			wdata = s_tdata[49:18];
			we = s_tvalid && s_tready && s_tdata[1:0] == CMD_WRITE
				&& s_tdata[9:2] < side_use && s_tdata[17:10] < side_use;
		end else if (st_q == S_WB) begin
			we = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= 8'd129; sweeps_q <= 4'd2; area_q <= 32'd262144;
			st_q <= S_IDLE; m_tvalid <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_SIDE: side_q <= cfg_data[7:0];
					REG_SWEEP: sweeps_q <= cfg_data[3:0];
					REG_AREA: area_q <= cfg_data;
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (st_q)
				S_IDLE: if (s_tvalid && s_tready) begin
					cmd_q <= s_tdata[1:0];
					ov_q <= !(s_tdata[9:2] < side_use && s_tdata[17:10] < side_use);
					if (s_tdata[1:0] == CMD_RUN) begin
						r_q <= 8'd1; c_q <= 8'd1; par_q <= 1'b0; it_q <= 4'd0;
						base_q <= AddrW'(GridSide + 1);
						st_q <= (sweeps_q == 4'd0 || side_use < 8'd3) ? S_OUT : S_PT;
					end else begin
						base_q <= AddrW'(s_tdata[17:10]) * AddrW'(GridSide)
							+ AddrW'(s_tdata[9:2]);
						st_q <= S_RD;
					end
				end
				S_RD: st_q <= S_OUT;
				S_OUT: begin
					m_tvalid <= 1'b1;
					out_q <= (cmd_q == CMD_READ && !ov_q) ? rdata_q : 32'd0;
					if (cmd_q == CMD_RUN) stat_q <= ST_RUN;
					else if (cmd_q == CMD_WRITE && !ov_q) stat_q <= ST_WRITE;
					else if (cmd_q == CMD_READ && !ov_q) stat_q <= ST_READ;
					else stat_q <= ST_RANGE;
					st_q <= S_IDLE;
				end
				S_PT: st_q <= ((r_q[0] ^ c_q[0]) == par_q) ? S_N0 : S_NEXT;
				S_N0: begin
					prod_q <= $signed(srcdata_q) * $signed({1'b0, area_q});
					st_q <= S_N1;
				end
				S_N1: begin
					nsum_q <= 35'(signed'(rdata_q)); st_q <= S_N2;
				end
				S_N2: begin nsum_q <= nsum_q + 35'(signed'(rdata_q)); st_q <= S_N3; end
				S_N3: begin nsum_q <= nsum_q + 35'(signed'(rdata_q)); st_q <= S_N4; end
				S_N4: begin nsum_q <= nsum_q + 35'(signed'(rdata_q)); st_q <= S_WB; end
				S_WB: st_q <= S_NEXT;
				S_NEXT: begin
					st_q <= S_PT;
					if (c_q + 8'd2 < side_use) begin
						c_q <= c_q + 8'd1; base_q <= base_q + AddrW'(1);
					end else if (r_q + 8'd2 < side_use) begin
						r_q <= r_q + 8'd1; c_q <= 8'd1;
						base_q <= AddrW'(r_q + 8'd1) * AddrW'(GridSide) + AddrW'(1);
					end else begin
						r_q <= 8'd1; c_q <= 8'd1; base_q <= AddrW'(GridSide + 1);
						par_q <= !par_q;
						if (par_q) begin
							it_q <= it_q + 4'd1;
							if (it_q + 4'd1 == sweeps_q) st_q <= S_OUT;
						end
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

`ifndef NO_ASSERTIONS
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !s_tready) else $error("accept while result pending");
	a_wb_range: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_WB) |-> (r_q >= 8'd1 && c_q >= 8'd1)) else $error("boundary write");
	a_rd_out: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == S_RD) |=> (st_q == S_OUT)) else $error("read flow");
`endif
endmodule
